@@ design/mfos_pkg.sv @@
// ----------------------------------------------------------------------------
// mfos_pkg
// Types and codes shared by the message FIFO core, its checker and testbench.
// ----------------------------------------------------------------------------
package mfos_pkg;

  // Item modes
  localparam logic [2:0] MODE_WRITE       = 3'd0;
  localparam logic [2:0] MODE_READ        = 3'd1;
  localparam logic [2:0] MODE_PEEK        = 3'd2;
  localparam logic [2:0] MODE_CLEAR       = 3'd3;
  localparam logic [2:0] MODE_RESET_STATS = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_LEN_ERR = 2'd3;

  // Width of one entry of the length store
  localparam int unsigned LEN_STORE_W = 7;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_byte;
    logic [6:0]  msg_length;
    logic        last_of_run;
    logic [4:0]  fill_count;
    logic        overflow_now;
    logic [15:0] overflow_total;
  } out_item_t;

endpackage

@@ design/message_fifo_with_overflow_stats_core.sv @@
// ----------------------------------------------------------------------------
// message_fifo_with_overflow_stats_core
// Circular FIFO of variable-length byte messages with overflow statistics.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_item_i) carries one command
//   item: write one message byte (committed at the byte marked last), read or
//   peek the oldest message, clear the ring, or zero the overflow statistics.
//   Output channel (out_valid_o / out_ready_i / out_item_o) returns results.
//   Every item gives one result, except a read or peek of a non-empty ring,
//   which gives one result per message byte, the final one marked
//   last_of_run. Each result carries fill count and overflow state.
//   Latency: write, clear, statistics reset and empty reads show their result
//   one cycle after acceptance. A read or peek first fetches the length from
//   the length store, then streams the bytes through the message memory's
//   read data register into the output register, one byte per cycle while
//   the receiver takes them, limited by the single read port of the memory.
//   Throughput: one write item per cycle while results are taken. A new item
//   is taken as soon as the output register is free or being taken.
//   Reset clears pointers, counts, flag and counter; the memories keep their
//   contents, which are only read after being written. A stalled receiver
//   holds the output register and pauses the byte stream, and no new item is
//   accepted until all results of the current item have gone out.
// ----------------------------------------------------------------------------
module message_fifo_with_overflow_stats_core #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned MSG_BYTES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mfos_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mfos_pkg::out_item_t out_item_o
);
  import mfos_pkg::*;

  // Slot index, byte position inside a slot, message count and length widths
  localparam int unsigned SLOT_W    = $clog2(DEPTH);
  localparam int unsigned POS_W     = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
  localparam int unsigned HW        = $clog2(DEPTH + 1);
  localparam int unsigned WP_W      = $clog2(MSG_BYTES + 2);
  localparam int unsigned LEN_W     = $clog2(MSG_BYTES + 1);
  localparam int unsigned MSG_DEPTH = DEPTH * (2 ** POS_W);

  localparam logic [HW-1:0]     FULL_CNT  = HW'(DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);
  localparam logic [WP_W-1:0]   MAX_POS   = WP_W'(MSG_BYTES);
  localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MSG_BYTES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN,
    S_STREAM
  } state_e;

  state_e             state_q, state_d;
  logic [SLOT_W-1:0]  head_q, head_d;
  logic [SLOT_W-1:0]  tail_q, tail_d;
  logic [HW-1:0]      held_q, held_d;
  logic               flag_q, flag_d;
  logic [15:0]        ovf_cnt_q, ovf_cnt_d;
  logic [WP_W-1:0]    wpos_q, wpos_d;
  logic               spoiled_q, spoiled_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [LEN_W-1:0]   idx_q, idx_d;
  logic               rd_vld_q, rd_vld_d;
  logic               rd_last_q, rd_last_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  // Memory ports
  logic                          msg_we;
  logic [$clog2(MSG_DEPTH)-1:0]  msg_waddr;
  logic                          msg_re;
  logic [$clog2(MSG_DEPTH)-1:0]  msg_raddr;
  logic [7:0]                    msg_rdata;
  logic                          len_we;
  logic [LEN_STORE_W-1:0]        len_wdata;
  logic                          len_re;
  logic [LEN_STORE_W-1:0]        len_rdata;

  logic               accept;
  logic               out_free;
  logic               move;
  logic               issue;
  logic               full;
  logic               pos_in_range;
  logic [WP_W-1:0]    wp_next;
  logic [LEN_W-1:0]   len_fetched;
  logic               res_load;
  logic [1:0]         res_status;

  function automatic logic [4:0] fill_of(input logic [HW-1:0] h);
    logic [15:0] e;
    e = 16'(h);
    return e[4:0];
  endfunction

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  // Byte stream: RAM data moves to the output register when it is free,
  // and a new read goes out only when the RAM data register can take it.
  assign move  = (state_q == S_STREAM) && rd_vld_q && out_free;
  assign issue = (state_q == S_STREAM) && (idx_q < len_q) && (!rd_vld_q || move);

  assign full         = (held_q == FULL_CNT);
  assign pos_in_range = (wpos_q < MAX_POS);
  assign wp_next      = (wpos_q <= MAX_POS) ? wpos_q + 1'b1 : wpos_q;

  // Clamp a fetched length to the slot size
  assign len_fetched = (len_rdata > LEN_STORE_W'(MSG_BYTES)) ? MAX_LEN
                                                             : LEN_W'(len_rdata);

  assign msg_waddr = {tail_q, wpos_q[POS_W-1:0]};
  assign msg_raddr = {slot_q, idx_q[POS_W-1:0]};
  assign msg_re    = issue;
  assign len_wdata = LEN_STORE_W'(wp_next);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    held_d      = held_q;
    flag_d      = flag_q;
    ovf_cnt_d   = ovf_cnt_q;
    wpos_d      = wpos_q;
    spoiled_d   = spoiled_q;
    slot_d      = slot_q;
    len_d       = len_q;
    idx_d       = idx_q;
    rd_vld_d    = rd_vld_q;
    rd_last_d   = rd_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    msg_we      = 1'b0;
    len_we      = 1'b0;
    len_re      = 1'b0;
    res_load    = 1'b0;
    res_status  = ST_OK;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_item_i.mode)
            MODE_WRITE: begin
              res_load = 1'b1;
              // store an in-range byte unless the ring is full, which spoils the message
              msg_we    = pos_in_range && !full;
              spoiled_d = spoiled_q || (pos_in_range && full);
              wpos_d    = wp_next;
              if (!in_item_i.last_byte) begin
                res_status = (wp_next > MAX_POS) ? ST_LEN_ERR : ST_OK;
              end else begin
                priority if (wp_next > MAX_POS) begin
                  res_status = ST_LEN_ERR;
                end else if (full || spoiled_d) begin
                  flag_d     = 1'b1;
                  ovf_cnt_d  = ovf_cnt_q + 16'd1;
                  res_status = ST_FULL;
                end else begin
                  // commit: record length, advance the tail
                  len_we     = 1'b1;
                  tail_d     = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
                  held_d     = held_q + 1'b1;
                  flag_d     = 1'b0;
                  res_status = ST_OK;
                end
                wpos_d    = '0;
                spoiled_d = 1'b0;
              end
            end
            MODE_READ, MODE_PEEK: begin
              if (held_q == '0) begin
                res_load   = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                // fetch the length of the oldest message
                len_re  = 1'b1;
                slot_d  = head_q;
                state_d = S_LEN;
                if (in_item_i.mode == MODE_READ) begin
                  head_d = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
                  held_d = held_q - 1'b1;
                end
              end
            end
            MODE_CLEAR: begin
              res_load  = 1'b1;
              head_d    = '0;
              tail_d    = '0;
              held_d    = '0;
              flag_d    = 1'b0;
              wpos_d    = '0;
              spoiled_d = 1'b0;
            end
            MODE_RESET_STATS: begin
              res_load  = 1'b1;
              ovf_cnt_d = '0;
              flag_d    = 1'b0;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_LEN: begin
        if (len_fetched == '0) begin
          res_load = 1'b1;
          state_d  = S_IDLE;
        end else begin
          len_d   = len_fetched;
          idx_d   = '0;
          state_d = S_STREAM;
        end
      end
      S_STREAM: begin
        if (issue) begin
          idx_d     = idx_q + 1'b1;
          rd_vld_d  = 1'b1;
          rd_last_d = (idx_q == len_q - 1'b1);
        end else if (move) begin
          rd_vld_d = 1'b0;
        end
        if (move) begin
          out_valid_d = 1'b1;
          out_d       = '{status:         ST_OK,
                          out_byte:       msg_rdata,
                          msg_length:     7'(len_q),
                          last_of_run:    rd_last_q,
                          fill_count:     fill_of(held_q),
                          overflow_now:   flag_q,
                          overflow_total: ovf_cnt_q};
          if (rd_last_q) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Single-result items report the state after their update
    if (res_load) begin
      out_valid_d = 1'b1;
      out_d       = '{status:         res_status,
                      out_byte:       8'd0,
                      msg_length:     7'd0,
                      last_of_run:    1'b1,
                      fill_count:     fill_of(held_d),
                      overflow_now:   flag_d,
                      overflow_total: ovf_cnt_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      held_q      <= '0;
      flag_q      <= 1'b0;
      ovf_cnt_q   <= '0;
      wpos_q      <= '0;
      spoiled_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      held_q      <= held_d;
      flag_q      <= flag_d;
      ovf_cnt_q   <= ovf_cnt_d;
      wpos_q      <= wpos_d;
      spoiled_q   <= spoiled_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and stream bookkeeping
  always_ff @(posedge clk_i) begin
    slot_q    <= slot_d;
    len_q     <= len_d;
    idx_q     <= idx_d;
    rd_last_q <= rd_last_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  mfos_ram #(
    .WIDTH (8),
    .DEPTH (MSG_DEPTH)
  ) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (msg_we),
    .waddr_i (msg_waddr),
    .wdata_i (in_item_i.data_byte),
    .re_i    (msg_re),
    .raddr_i (msg_raddr),
    .rdata_o (msg_rdata)
  );

  mfos_ram #(
    .WIDTH (LEN_STORE_W),
    .DEPTH (DEPTH)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (tail_q),
    .wdata_i (len_wdata),
    .re_i    (len_re),
    .raddr_i (head_q),
    .rdata_o (len_rdata)
  );

`ifndef SYNTHESIS
  // Message count never exceeds the ring size
  assert property (@(posedge clk_i) disable iff (!rst_ni) held_q <= FULL_CNT)
    else $error("held count above ring depth");

  // An empty or full ring has head and tail on the same slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == '0 || held_q == FULL_CNT) |-> (head_q == tail_q))
    else $error("ring pointers disagree with held count");

  // Fetched message bytes exist only while streaming
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == S_STREAM))
    else $error("pending read data outside stream state");

  // Write position saturates one past the slot size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpos_q <= MAX_POS + 1'b1)
    else $error("write position out of range");
`endif

endmodule

@@ design/mfos_ram.sv @@
// ----------------------------------------------------------------------------
// mfos_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mfos_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ verif/mfos_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mfos_result_checker
// Watches both channels of the message FIFO core, keeps its own copy of the
// ring, the open message and the overflow statistics, and compares every
// result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module mfos_result_checker #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned MSG_BYTES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  mfos_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  mfos_pkg::out_item_t out_item_i,
  output int                  fail_count_o,
  output int                  replies_pending_o
);
  import mfos_pkg::*;

  localparam int MAX_REPORTS = 100;

  // Ring contents and bookkeeping
  logic [7:0]             msg_mem [DEPTH][MSG_BYTES];
  logic [LEN_STORE_W-1:0] len_mem [DEPTH];
  int unsigned            head_idx;
  int unsigned            tail_idx;
  int unsigned            held_cnt;
  logic                   ovf_flag;
  logic [15:0]            ovf_total;
  int unsigned            wr_pos;
  logic                   wr_spoiled;

  out_item_t due_replies_q [$];
  out_item_t want;

  function automatic out_item_t make_reply(logic [1:0] st, logic [7:0] byte_val,
                                           logic [6:0] len, logic final_one);
    out_item_t r;
    r.status         = st;
    r.out_byte       = byte_val;
    r.msg_length     = len;
    r.last_of_run    = final_one;
    r.fill_count     = held_cnt[4:0];
    r.overflow_now   = ovf_flag;
    r.overflow_total = ovf_total;
    return r;
  endfunction

  // Apply one accepted item to the ring and queue the results it causes.
  task automatic advance_ring(in_item_t it);
    logic [1:0]  st;
    int unsigned len;
    int unsigned slot;
    case (it.mode)
      MODE_WRITE: begin
        if (wr_pos < MSG_BYTES) begin
          if (held_cnt < DEPTH) msg_mem[tail_idx][wr_pos] = it.data_byte;
          else wr_spoiled = 1'b1;
        end
        if (wr_pos <= MSG_BYTES) wr_pos++;
        if (!it.last_byte) begin
          st = (wr_pos > MSG_BYTES) ? ST_LEN_ERR : ST_OK;
        end else begin
          if (wr_pos > MSG_BYTES) begin
            st = ST_LEN_ERR;
          end else if (held_cnt >= DEPTH || wr_spoiled) begin
            ovf_flag  = 1'b1;
            ovf_total = ovf_total + 16'd1;
            st        = ST_FULL;
          end else begin
            len_mem[tail_idx] = wr_pos[LEN_STORE_W-1:0];
            tail_idx          = (tail_idx + 1) % DEPTH;
            held_cnt++;
            ovf_flag          = 1'b0;
            st                = ST_OK;
          end
          wr_pos     = 0;
          wr_spoiled = 1'b0;
        end
        due_replies_q.push_back(make_reply(st, 8'd0, 7'd0, 1'b1));
      end
      MODE_READ, MODE_PEEK: begin
        if (held_cnt == 0) begin
          due_replies_q.push_back(make_reply(ST_EMPTY, 8'd0, 7'd0, 1'b1));
        end else begin
          slot = head_idx;
          len  = 32'(len_mem[slot]);
          if (len > MSG_BYTES) len = MSG_BYTES;
          if (it.mode == MODE_READ) begin
            head_idx = (head_idx + 1) % DEPTH;
            held_cnt--;
          end
          if (len == 0) begin
            due_replies_q.push_back(make_reply(ST_OK, 8'd0, 7'd0, 1'b1));
          end else begin
            for (int i = 0; i < len; i++) begin
              due_replies_q.push_back(make_reply(ST_OK, msg_mem[slot][i], len[6:0],
                                                 (i + 1 == len)));
            end
          end
        end
      end
      MODE_CLEAR: begin
        head_idx   = 0;
        tail_idx   = 0;
        held_cnt   = 0;
        ovf_flag   = 1'b0;
        wr_pos     = 0;
        wr_spoiled = 1'b0;
        due_replies_q.push_back(make_reply(ST_OK, 8'd0, 7'd0, 1'b1));
      end
      MODE_RESET_STATS: begin
        ovf_total = 16'd0;
        ovf_flag  = 1'b0;
        due_replies_q.push_back(make_reply(ST_OK, 8'd0, 7'd0, 1'b1));
      end
      default: begin
        due_replies_q.push_back(make_reply(ST_OK, 8'd0, 7'd0, 1'b1));
      end
    endcase
  endtask

  task automatic check_field(string field, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      fail_count_o++;
      if (fail_count_o <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0d, actual %0d",
                 $time, field, exp_val, act_val);
    end
  endtask

  // Compare results first: a result can never belong to an item accepted at
  // the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_idx     = 0;
      tail_idx     = 0;
      held_cnt     = 0;
      ovf_flag     = 1'b0;
      ovf_total    = 16'd0;
      wr_pos       = 0;
      wr_spoiled   = 1'b0;
      fail_count_o = 0;
      due_replies_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_replies_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MAX_REPORTS)
            $display("%0t: unexpected result: expected none, actual %h",
                     $time, out_item_i);
        end else begin
          want = due_replies_q.pop_front();
          check_field("status", 32'(want.status), 32'(out_item_i.status));
          check_field("out_byte", 32'(want.out_byte), 32'(out_item_i.out_byte));
          check_field("msg_length", 32'(want.msg_length), 32'(out_item_i.msg_length));
          check_field("last_of_run", 32'(want.last_of_run),
                      32'(out_item_i.last_of_run));
          check_field("fill_count", 32'(want.fill_count), 32'(out_item_i.fill_count));
          check_field("overflow_now", 32'(want.overflow_now),
                      32'(out_item_i.overflow_now));
          check_field("overflow_total", 32'(want.overflow_total),
                      32'(out_item_i.overflow_total));
        end
      end
      if (in_valid_i && in_ready_i) advance_ring(in_item_i);
    end
    replies_pending_o = due_replies_q.size();
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives command items into the message FIFO core: a short directed walk,
// then well-formed messages, reads and peeks of random content mixed with
// fills, overflows, spoiled and over-long messages, clears and noise. The
// sender idles in bursts, the receiver stalls on its own pattern, and a
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import mfos_pkg::*;

  localparam int unsigned DEPTH         = 16;
  localparam int unsigned MSG_BYTES     = 64;
  localparam int          RANDOM_BUDGET = 330;
  localparam int          TAIL_CYCLES   = 8;
  localparam int          LIMIT_CYCLES  = 1000000;
  // Highest mode code; the codes above statistics reset are ignored
  localparam logic [2:0]  MODE_TOP      = 3'd7;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  int fail_count;
  int replies_pending;
  int commands_sent;
  int burst_left;
  int cycle_count;
  int pick;

  message_fifo_with_overflow_stats_core #(
    .DEPTH     (DEPTH),
    .MSG_BYTES (MSG_BYTES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  mfos_result_checker #(
    .DEPTH     (DEPTH),
    .MSG_BYTES (MSG_BYTES)
  ) u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .in_item_i         (in_item_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_item_i        (out_item_o),
    .fail_count_o      (fail_count),
    .replies_pending_o (replies_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stop a hung run and report it as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // Receiver: stretches of always-ready, coin-flip, periodic and sparse ready.
  initial begin
    int style;
    int run_len;
    int period;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      style   = $urandom_range(0, 3);
      run_len = $urandom_range(20, 100);
      period  = $urandom_range(2, 5);
      for (int j = 0; j < run_len; j++) begin
        @(negedge clk_i);
        case (style)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= (j % period) != 0;
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Present one item and hold it until accepted. When a burst runs out,
  // drop valid for a random gap before the next item.
  task automatic send_item(logic [2:0] mode, logic [7:0] data, logic is_last);
    if (burst_left == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= '{mode: mode, data_byte: data, last_byte: is_last};
    do @(posedge clk_i); while (!in_ready_o);
    if (mode <= MODE_RESET_STATS) commands_sent++;
  endtask

  // Non-write commands carry random filler in the data and last fields.
  task automatic send_cmd(logic [2:0] mode);
    send_item(mode, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Write a whole message of random bytes, last mark on the final byte.
  task automatic send_message(int len);
    for (int i = 0; i < len; i++)
      send_item(MODE_WRITE, 8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // Hold off the sender until every predicted result has come out.
  task automatic hold_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (replies_pending != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    commands_sent = 0;
    burst_left    = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed walk: empty reads, smallest messages, extreme bytes, peek
    // versus read, clear of an open message, spare modes.
    send_item(MODE_READ, 8'h00, 1'b0);
    send_item(MODE_PEEK, 8'hFF, 1'b1);
    send_item(MODE_WRITE, 8'h00, 1'b1);
    send_item(MODE_WRITE, 8'hFF, 1'b0);
    send_item(MODE_WRITE, 8'h5A, 1'b0);
    send_item(MODE_WRITE, 8'hA5, 1'b1);
    send_cmd(MODE_PEEK);
    send_cmd(MODE_READ);
    send_cmd(MODE_READ);
    send_cmd(MODE_READ);
    send_item(MODE_WRITE, 8'h81, 1'b0);
    send_item(MODE_WRITE, 8'h7E, 1'b0);
    send_cmd(MODE_CLEAR);
    send_cmd(MODE_READ);
    send_cmd(MODE_RESET_STATS);
    for (logic [3:0] m = 4'(MODE_RESET_STATS) + 4'd1; m <= MODE_TOP; m++)
      send_cmd(m[2:0]);
    send_item(MODE_WRITE, 8'h80, 1'b1);
    send_cmd(MODE_READ);
    hold_until_drained();

    // Longest legal message, then one to four bytes past the limit so the
    // position saturates and the length error shows.
    commands_sent = 0;
    send_message(MSG_BYTES);
    send_message(MSG_BYTES + $urandom_range(1, 4));
    send_cmd(MODE_PEEK);
    send_cmd(MODE_READ);
    send_cmd(MODE_READ);

    while (commands_sent < RANDOM_BUDGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_message($urandom_range(1, 8));
      end else if (pick < 33) begin
        send_message($urandom_range(9, MSG_BYTES));
      end else if (pick < 53) begin
        send_cmd(MODE_READ);
      end else if (pick < 59) begin
        send_cmd(MODE_PEEK);
      end else if (pick < 62) begin
        // Fill the ring and push at least one message past it
        repeat (DEPTH + 1) send_message($urandom_range(1, 2));
      end else if (pick < 64) begin
        // Fill, start a message that meets the full ring, free a slot
        // mid-message, then finish it: still refused as spoiled
        repeat (DEPTH) send_message(1);
        send_item(MODE_WRITE, 8'($urandom_range(0, 255)), 1'b0);
        send_cmd(MODE_READ);
        send_item(MODE_WRITE, 8'($urandom_range(0, 255)), 1'b1);
      end else if (pick < 67) begin
        // Drop an open message
        repeat ($urandom_range(1, 4))
          send_item(MODE_WRITE, 8'($urandom_range(0, 255)), 1'b0);
        send_cmd(MODE_CLEAR);
      end else if (pick < 70) begin
        send_cmd(MODE_RESET_STATS);
      end else if (pick < 72) begin
        send_cmd(MODE_CLEAR);
      end else if (pick < 78) begin
        repeat ($urandom_range(2, DEPTH)) send_cmd(MODE_READ);
      end else if (pick < 80) begin
        hold_until_drained();
      end else begin
        send_item(3'($urandom_range(0, MODE_TOP)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end
    end

    hold_until_drained();
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ files.f @@
design/mfos_pkg.sv
design/mfos_ram.sv
design/message_fifo_with_overflow_stats_core.sv
verif/mfos_result_checker.sv
verif/testbench.sv
